@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the filter modules. Every check is sampled
// on the rising clock edge and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define AST_ON(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must be followed by a consequence on the next clock edge.
`define AST_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/core/mar_pkg.sv @@
package mar_pkg;

   localparam int MAX_ORDER  = 6;
   localparam int TAP_W      = $clog2(MAX_ORDER + 1);
   localparam int IDX_W      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   localparam int SAMPLE_W   = 24;
   localparam int THETA_W    = 16;
   localparam int ORDER_W    = 3;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int ACC_W      = 28;
   localparam int Q_SHIFT    = 14;
   localparam int SQ_W       = 63;
   localparam int ABS_W      = 40;
   localparam int CNT_W      = 32;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 184;

   localparam logic [CSR_ADDR_W-1:0] CSR_MEAN_LEVEL = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ORDER      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_THETA_1    = 3'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_PRED,
      ST_RES,
      ST_SQ,
      ST_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             accept;
      logic             mac;
      logic [IDX_W-1:0] tap;
      logic             pred;
      logic             res;
      logic             square;
      logic             acc;
      logic             load;
   } cmd_type;

   typedef struct packed {
      logic             start_warm;
      logic [TAP_W-1:0] start_taps;
      logic             out_free;
   } status_type;

   // Clamp a wide signed value into the signed Q16.8 range.
   function automatic logic signed [SAMPLE_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}));
      lo = ACC_W'(signed'({1'b1, {(SAMPLE_W-1){1'b0}}}));
      if (v > hi) begin
         sat_q = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (v < lo) begin
         sat_q = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sat_q = v[SAMPLE_W-1:0];
      end
   endfunction

endpackage

@@ rtl/core/moving_average_residual_filter.sv @@
// Moving-average residual filter. Each request word carries one Q16.8 sample
// (tdata) and a new-series flag (tuser) that clears the residual history,
// the warm-up count and the error sums before that sample is used. Each
// sample yields exactly one response word with the prediction, the residual,
// the saturating running sums of squared and absolute error and the scored
// count; tuser marks whether the sample was scored. The first 'order'
// samples of a series only warm up the history: their prediction is the
// mean level and they are not scored. Words are processed one at a time:
// after a word is accepted the controller issues one MAC step per tap
// and a drain step, both skipped when no taps are used (warm-up or order
// zero), then the prediction, residual, square and accumulate steps, and
// loads the result once the output register is free, waiting while the
// previous result there is still untaken. The controller is ready again
// in the cycle after it loads a result. A single shared multiplier serves
// one tap per cycle and then squares the residual. The output register
// lets the next word be accepted while a finished result still waits to
// be taken. Configuration registers are written through the csr port,
// index 0 mean_level, 1 order (values above six act as six), 2 to 7
// theta_1 to theta_6, and should only change while the block is idle.
module moving_average_residual_filter (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration write port.
   input  logic                               csr_we,
   input  logic [mar_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [mar_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // Request stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mar_pkg::REQ_DATA_W-1:0]     req_tdata,   // sample[23:0]
   input  logic                               req_tuser,   // new_series
   // Response stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // prediction[23:0], residual[47:24], sum_sq_error[110:48],
   // sum_abs_error[150:111], scored_count[182:151], zero pad [183]
   output logic [mar_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser    // scored
);
   import mar_pkg::*;

   // The controller sequences the taps and steps; the datapath holds the
   // configuration, history, sums and the output register.
   cmd_type    cmd;
   status_type status;

   mar_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mar_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/core/mar_ctrl.sv @@
`include "assert_macros.svh"

module mar_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mar_pkg::status_type  status,
   output mar_pkg::cmd_type     cmd
);
   import mar_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] tap_ff, tap_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic             mac_last;

   assign mac_last = (state_ff == ST_MAC) && (tap_ff == last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      tap_in     = tap_ff;
      last_in    = last_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.tap    = tap_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.start_warm || status.start_taps == '0) begin
                  state_in = ST_PRED;
               end else begin
                  state_in = ST_MAC;
                  tap_in   = '0;
                  last_in  = IDX_W'(status.start_taps - TAP_W'(1));
               end
            end
         end
         ST_MAC: begin
            cmd.mac = 1'b1;
            if (tap_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_PRED;
         end
         ST_PRED: begin
            cmd.pred = 1'b1;
            state_in = ST_RES;
         end
         ST_RES: begin
            cmd.res  = 1'b1;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.square = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `AST_ON(a_tap_bound, (state_ff == ST_MAC) |-> (tap_ff <= last_ff), "tap index past last tap")
   `AST_NEXT(a_mac_ends, mac_last, state_ff == ST_DRAIN, "MAC did not end in drain")

endmodule

@@ rtl/core/mar_dp.sv @@
`include "assert_macros.svh"

module mar_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [mar_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [mar_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [mar_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                 req_tuser,
   input  mar_pkg::cmd_type                     cmd,
   output mar_pkg::status_type                  status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mar_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tuser
);
   import mar_pkg::*;

   // Configuration.
   logic signed [SAMPLE_W-1:0] mean_ff, mean_in;
   logic [ORDER_W-1:0]         order_ff, order_in;
   logic signed [THETA_W-1:0]  theta_ff [MAX_ORDER];
   logic signed [THETA_W-1:0]  theta_in [MAX_ORDER];

   // Series state.
   logic signed [SAMPLE_W-1:0] hist_ff [MAX_ORDER];
   logic signed [SAMPLE_W-1:0] hist_in [MAX_ORDER];
   logic [TAP_W-1:0]           warmup_ff, warmup_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic [ABS_W-1:0]           abs_ff, abs_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;

   // Per-word working registers.
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       warm_ff, warm_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       prod_vld_ff, prod_vld_in;
   logic signed [SAMPLE_W-1:0] pred_ff, pred_in;
   logic signed [SAMPLE_W-1:0] res_ff, res_in;

   // Output register.
   logic                       rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                       rsp_scored_ff, rsp_scored_in;

   logic [TAP_W-1:0]           eff;
   logic [TAP_W-1:0]           warmup_start;
   logic [CSR_ADDR_W-1:0]      theta_idx;
   logic signed [SAMPLE_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0]   product;
   logic signed [ACC_W-1:0]    diff;
   logic [SAMPLE_W-1:0]        abs_val;
   logic [SQ_W:0]              sq_sum;
   logic [ABS_W:0]             abs_sum;

   assign eff = (order_ff > ORDER_W'(MAX_ORDER)) ? TAP_W'(MAX_ORDER) : TAP_W'(order_ff);
   assign warmup_start      = req_tuser ? '0 : warmup_ff;
   assign status.start_warm = warmup_start < eff;
   assign status.start_taps = eff;
   assign status.out_free   = !rsp_vld_ff || rsp_tready;

   assign theta_idx = csr_addr - CSR_THETA_1;

   // One shared multiplier: theta times history during the taps, residual
   // squared afterwards.
   always_comb begin
      if (cmd.square) begin
         mul_a = res_ff;
         mul_b = res_ff;
      end else begin
         mul_a = SAMPLE_W'(theta_ff[cmd.tap]);
         mul_b = hist_ff[cmd.tap];
      end
   end
   assign product = mul_a * mul_b;

   assign diff    = ACC_W'(sample_ff) - ACC_W'(pred_ff);
   assign abs_val = res_ff[SAMPLE_W-1] ? SAMPLE_W'(-res_ff) : SAMPLE_W'(res_ff);
   assign sq_sum  = {1'b0, sq_ff} + (SQ_W+1)'(prod_ff[PROD_W-2:0]);
   assign abs_sum = {1'b0, abs_ff} + (ABS_W+1)'(abs_val);

   always_comb begin
      mean_in       = mean_ff;
      order_in      = order_ff;
      theta_in      = theta_ff;
      hist_in       = hist_ff;
      warmup_in     = warmup_ff;
      sq_in         = sq_ff;
      abs_in        = abs_ff;
      cnt_in        = cnt_ff;
      sample_in     = sample_ff;
      warm_in       = warm_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      prod_vld_in   = cmd.mac;
      pred_in       = pred_ff;
      res_in        = res_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_scored_in = rsp_scored_ff;
      rsp_vld_in    = rsp_vld_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_MEAN_LEVEL: mean_in  = csr_wdata[SAMPLE_W-1:0];
            CSR_ORDER:      order_in = csr_wdata[ORDER_W-1:0];
            default: begin
               if (csr_addr >= CSR_THETA_1 && theta_idx < CSR_ADDR_W'(MAX_ORDER)) begin
                  theta_in[theta_idx[IDX_W-1:0]] = csr_wdata[THETA_W-1:0];
               end
            end
         endcase
      end

      if (cmd.accept) begin
         sample_in = req_tdata[SAMPLE_W-1:0];
         warm_in   = status.start_warm;
         acc_in    = ACC_W'(mean_ff);
         if (req_tuser) begin
            for (int k = 0; k < MAX_ORDER; k++) begin
               hist_in[k] = '0;
            end
            warmup_in = '0;
            sq_in     = '0;
            abs_in    = '0;
            cnt_in    = '0;
         end
      end

      if (cmd.mac || cmd.square) begin
         prod_in = product;
      end

      // Products land in the cycle after their tap is issued.
      if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff >>> Q_SHIFT);
      end

      if (cmd.pred) begin
         pred_in = warm_ff ? mean_ff : sat_q(acc_ff);
      end

      if (cmd.res) begin
         res_in = sat_q(diff);
         for (int k = MAX_ORDER - 1; k > 0; k--) begin
            hist_in[k] = hist_ff[k-1];
         end
         hist_in[0] = res_in;
         if (warm_ff) begin
            warmup_in = warmup_ff + TAP_W'(1);
         end
      end

      if (cmd.acc && !warm_ff) begin
         sq_in  = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
         abs_in = abs_sum[ABS_W] ? '1 : abs_sum[ABS_W-1:0];
         if (cnt_ff != '1) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end

      if (cmd.load) begin
         rsp_vld_in    = 1'b1;
         rsp_scored_in = !warm_ff;
         rsp_data_in   = {1'b0, cnt_ff, abs_ff, sq_ff, res_ff, pred_ff};
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_in_reset: begin
            mean_ff     <= '0;
            order_ff    <= '0;
            for (int k = 0; k < MAX_ORDER; k++) begin
               theta_ff[k] <= '0;
               hist_ff[k]  <= '0;
            end
            warmup_ff   <= '0;
            sq_ff       <= '0;
            abs_ff      <= '0;
            cnt_ff      <= '0;
            prod_vld_ff <= 1'b0;
            rsp_vld_ff  <= 1'b0;
            warm_ff     <= 1'b0;
         end
      end else begin
         mean_ff     <= mean_in;
         order_ff    <= order_in;
         theta_ff    <= theta_in;
         hist_ff     <= hist_in;
         warmup_ff   <= warmup_in;
         sq_ff       <= sq_in;
         abs_ff      <= abs_in;
         cnt_ff      <= cnt_in;
         prod_vld_ff <= prod_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         warm_ff     <= warm_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      pred_ff       <= pred_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_scored_ff <= rsp_scored_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_scored_ff;

   `AST_ON(a_warmup_bound, warmup_ff <= TAP_W'(MAX_ORDER), "warm-up count beyond maximum order")
   `AST_ON(a_load_free, cmd.load |-> (!rsp_vld_ff || rsp_tready), "result overwrote a pending word")
   `AST_ON(a_no_accept_busy, prod_vld_ff |-> !cmd.accept, "word accepted while taps in flight")

endmodule

@@ tb/tb_moving_average_residual_filter.sv @@
module tb_moving_average_residual_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import mar_pkg::*;

   // The csr port exposes all eight register indexes; the package names the
   // first theta, and the remaining weights sit on the indexes that follow it.
   localparam logic [CSR_ADDR_W-1:0] REG_THETA_2 = CSR_THETA_1 + 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_THETA_3 = CSR_THETA_1 + 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_THETA_4 = CSR_THETA_1 + 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_THETA_5 = CSR_THETA_1 + 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_THETA_6 = CSR_THETA_1 + 3'd5;

   localparam logic [SAMPLE_W-1:0] Q_TOP    = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] Q_BOTTOM = 24'h800000;
   localparam logic [THETA_W-1:0]  W_TOP    = 16'h7FFF;
   localparam logic [THETA_W-1:0]  W_BOTTOM = 16'h8000;
   localparam logic [SQ_W-1:0]     SQ_FULL  = '1;
   localparam logic [ABS_W-1:0]    ABS_FULL = '1;
   localparam logic [CNT_W-1:0]    CNT_FULL = '1;

   // A run of this many cycles without any word moving on either channel
   // means the block has hung.
   localparam int STALL_LIMIT = 5000;
   localparam int RANDOM_PHASES = 8;
   localparam int WORDS_PER_PHASE = 100;

   typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_type;

   // One line of the stimulus plan. A write line sets one register; a word
   // line sends one sample. When 'known' is set the prediction, residual and
   // scored flag are typed into the line instead of taken from the model.
   typedef struct {
      row_kind_type               kind;
      logic [CSR_ADDR_W-1:0]      reg_index;
      logic [CSR_DATA_W-1:0]      reg_value;
      logic [SAMPLE_W-1:0]        sample;
      logic                       new_series;
      logic                       known;
      logic signed [SAMPLE_W-1:0] known_prediction;
      logic signed [SAMPLE_W-1:0] known_residual;
      logic                       known_scored;
   } stim_row_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] prediction;
      logic signed [SAMPLE_W-1:0] residual;
      logic                       scored;
      logic [SQ_W-1:0]            sum_sq_error;
      logic [ABS_W-1:0]           sum_abs_error;
      logic [CNT_W-1:0]           scored_count;
   } filter_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // sample[23:0]
   logic                  req_tuser = 1'b0; // new_series
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // prediction[23:0], residual[47:24], sum_sq_error[110:48],
   // sum_abs_error[150:111], scored_count[182:151], zero pad [183]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;        // scored

   moving_average_residual_filter DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Our own copy of the filter: the configuration as last written and the
   // per-series history and error sums.
   logic signed [SAMPLE_W-1:0] model_mean;
   logic [ORDER_W-1:0]         model_order;
   logic signed [THETA_W-1:0]  model_theta [MAX_ORDER];
   logic signed [SAMPLE_W-1:0] past_residual [MAX_ORDER];
   int                         warmup_count;
   logic [SQ_W-1:0]            square_total;
   logic [ABS_W-1:0]           absolute_total;
   logic [CNT_W-1:0]           scored_total;

   filter_result_type pending_results[$];
   stim_row_type      plan[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int errors = 0;
   int words_sent = 0;
   int results_seen = 0;
   int scored_seen = 0;
   int settings_used = 0;

   function automatic logic signed [SAMPLE_W-1:0] clamp_q(input longint v);
      if (v > 64'sd8388607) begin
         return Q_TOP;
      end else if (v < -64'sd8388608) begin
         return Q_BOTTOM;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic void clear_series();
      foreach (past_residual[k]) past_residual[k] = '0;
      warmup_count = 0;
      square_total = '0;
      absolute_total = '0;
      scored_total = '0;
   endfunction

   function automatic void set_register(input logic [CSR_ADDR_W-1:0] index,
                                        input logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_MEAN_LEVEL: begin
            model_mean = value;
         end
         CSR_ORDER: begin
            model_order = value[ORDER_W-1:0];
         end
         default: begin
            model_theta[index - CSR_THETA_1] = value[THETA_W-1:0];
         end
      endcase
   endfunction

   // Residual recursion for one sample: warm-up samples only fill the history,
   // later ones are predicted from the weighted past residuals and scored.
   function automatic filter_result_type filter_sample(input logic [SAMPLE_W-1:0] sample,
                                                       input logic new_series);
      filter_result_type r;
      longint            acc;
      longint            sq;
      longint            mag;
      int                taps;
      logic [SQ_W:0]     sq_wide;
      logic [ABS_W:0]    abs_wide;
      taps = (model_order > ORDER_W'(MAX_ORDER)) ? MAX_ORDER : int'(model_order);
      if (new_series) clear_series();
      if (warmup_count < taps) begin
         r.prediction = model_mean;
         r.residual = clamp_q(longint'($signed(sample)) - longint'(model_mean));
         r.scored = 1'b0;
         warmup_count++;
      end else begin
         acc = longint'(model_mean);
         for (int k = 0; k < taps; k++) begin
            acc += (longint'(model_theta[k]) * longint'(past_residual[k])) >>> Q_SHIFT;
         end
         r.prediction = clamp_q(acc);
         r.residual = clamp_q(longint'($signed(sample)) - longint'(r.prediction));
         r.scored = 1'b1;
      end
      for (int k = MAX_ORDER - 1; k > 0; k--) past_residual[k] = past_residual[k-1];
      past_residual[0] = r.residual;
      if (r.scored) begin
         sq = longint'(r.residual) * longint'(r.residual);
         mag = (r.residual < 0) ? -longint'(r.residual) : longint'(r.residual);
         sq_wide = {1'b0, square_total} + (SQ_W+1)'(sq);
         abs_wide = {1'b0, absolute_total} + (ABS_W+1)'(mag);
         square_total = (sq_wide > {1'b0, SQ_FULL}) ? SQ_FULL : sq_wide[SQ_W-1:0];
         absolute_total = (abs_wide > {1'b0, ABS_FULL}) ? ABS_FULL : abs_wide[ABS_W-1:0];
         if (scored_total != CNT_FULL) scored_total++;
      end
      r.sum_sq_error = square_total;
      r.sum_abs_error = absolute_total;
      r.scored_count = scored_total;
      return r;
   endfunction

   function automatic stim_row_type write_line(input logic [CSR_ADDR_W-1:0] index,
                                               input logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row = '{kind: ROW_WRITE, default: '0};
      row.reg_index = index;
      row.reg_value = value;
      return row;
   endfunction

   function automatic stim_row_type word_line(input logic [SAMPLE_W-1:0] sample,
                                              input logic new_series);
      stim_row_type row;
      row = '{kind: ROW_WORD, default: '0};
      row.sample = sample;
      row.new_series = new_series;
      return row;
   endfunction

   function automatic stim_row_type known_line(input logic [SAMPLE_W-1:0] sample,
                                               input logic new_series,
                                               input logic signed [SAMPLE_W-1:0] prediction,
                                               input logic signed [SAMPLE_W-1:0] residual,
                                               input logic scored);
      stim_row_type row;
      row = word_line(sample, new_series);
      row.known = 1'b1;
      row.known_prediction = prediction;
      row.known_residual = residual;
      row.known_scored = scored;
      return row;
   endfunction

   // Appends one line to the end of the stimulus plan.
   function automatic void add_line(input stim_row_type row);
      plan.insert(plan.size(), row);
   endfunction

   // Drives one register write. The enable is left high so that writes can
   // follow back to back; the caller drops it before the next sample.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      set_register(index, value);
   endtask

   // Sends one sample word, with a random gap ahead of it when the sender is
   // set to idle. Once the word is taken its expected result is queued.
   task automatic send_row(input stim_row_type row);
      filter_result_type r;
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= row.sample;
      req_tuser <= row.new_series;
      do @(posedge clock); while (!req_tready);
      r = filter_sample(row.sample, row.new_series);
      if (row.known) begin
         r.prediction = row.known_prediction;
         r.residual = row.known_residual;
         r.scored = row.known_scored;
      end
      pending_results.insert(pending_results.size(), r);
      words_sent++;
   endtask

   // Registers may only change with the block empty. Every sample yields a
   // result, so an empty queue of expectations means nothing is in flight;
   // a further wait then lets the output register settle.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return SAMPLE_W'($urandom_range(8192) - 4096);
      end else if (pick < 85) begin
         return SAMPLE_W'($urandom);
      end
      case ($urandom_range(4))
         0: return Q_TOP;
         1: return Q_BOTTOM;
         2: return '0;
         3: return '1;
         default: return SAMPLE_W'(1);
      endcase
   endfunction

   function automatic logic [THETA_W-1:0] random_theta();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         return THETA_W'($urandom_range(16384) - 8192);
      end else if (pick < 85) begin
         return THETA_W'($urandom);
      end
      case ($urandom_range(2))
         0: return W_TOP;
         1: return W_BOTTOM;
         default: return '0;
      endcase
   endfunction

   // Response side: stalls at random, and checks every word it takes against
   // the oldest expectation, field by field.
   task automatic check_result();
      filter_result_type want;
      results_seen++;
      if (rsp_tuser) scored_seen++;
      if (pending_results.size() == 0) begin
         $error("result word with no sample waiting for it");
         errors++;
         return;
      end
      want = pending_results.pop_front();
      if (rsp_tdata[23:0] !== want.prediction) begin
         $error("prediction mismatch: expected %0d, actual %0d",
                want.prediction, $signed(rsp_tdata[23:0]));
         errors++;
      end
      if (rsp_tdata[47:24] !== want.residual) begin
         $error("residual mismatch: expected %0d, actual %0d",
                want.residual, $signed(rsp_tdata[47:24]));
         errors++;
      end
      if (rsp_tuser !== want.scored) begin
         $error("scored mismatch: expected %0d, actual %0d", want.scored, rsp_tuser);
         errors++;
      end
      if (rsp_tdata[110:48] !== want.sum_sq_error) begin
         $error("sum_sq_error mismatch: expected %0d, actual %0d",
                want.sum_sq_error, rsp_tdata[110:48]);
         errors++;
      end
      if (rsp_tdata[150:111] !== want.sum_abs_error) begin
         $error("sum_abs_error mismatch: expected %0d, actual %0d",
                want.sum_abs_error, rsp_tdata[150:111]);
         errors++;
      end
      if (rsp_tdata[182:151] !== want.scored_count) begin
         $error("scored_count mismatch: expected %0d, actual %0d",
                want.scored_count, rsp_tdata[182:151]);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         if (rsp_tvalid && rsp_tready) check_result();
      end
   end

   // Watchdog: any word moving on either channel restarts the count.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      model_mean = '0;
      model_order = '0;
      foreach (model_theta[k]) model_theta[k] = '0;
      clear_series();

      // Directed plan. After reset the mean level and order are zero, so
      // every sample is scored and the residual is the sample itself.
      add_line(known_line(Q_TOP, 1'b1, 24'sd0, 24'sd8388607, 1'b1));
      add_line(known_line(Q_BOTTOM, 1'b0, 24'sd0, -24'sd8388608, 1'b1));
      add_line(known_line('0, 1'b0, 24'sd0, 24'sd0, 1'b1));
      // Extreme mean levels push the residual into saturation both ways.
      add_line(write_line(CSR_MEAN_LEVEL, Q_TOP));
      add_line(known_line(Q_BOTTOM, 1'b0, 24'sd8388607, -24'sd8388608, 1'b1));
      add_line(write_line(CSR_MEAN_LEVEL, Q_BOTTOM));
      add_line(known_line(Q_TOP, 1'b0, -24'sd8388608, 24'sd8388607, 1'b1));
      // Order two with the extreme weights: a new series warms up for two
      // samples (prediction equals the mean level of 1.0), then scores.
      add_line(write_line(CSR_MEAN_LEVEL, 24'h000100));
      add_line(write_line(CSR_ORDER, 24'd2));
      add_line(write_line(CSR_THETA_1, 24'(W_TOP)));
      add_line(write_line(REG_THETA_2, 24'(W_BOTTOM)));
      add_line(known_line(24'h000500, 1'b1, 24'sd256, 24'sd1024, 1'b0));
      add_line(known_line(24'h000300, 1'b0, 24'sd256, 24'sd512, 1'b0));
      add_line(word_line('0, 1'b0));
      add_line(word_line(Q_TOP, 1'b0));
      add_line(word_line(Q_BOTTOM, 1'b0));
      // Order seven acts as six. Raising the order mid-series extends the
      // warm-up by four more samples while the history is kept.
      add_line(write_line(CSR_MEAN_LEVEL, '0));
      add_line(write_line(CSR_ORDER, 24'd7));
      add_line(write_line(REG_THETA_3, 24'(W_TOP)));
      add_line(write_line(REG_THETA_4, 24'(W_BOTTOM)));
      add_line(write_line(REG_THETA_5, 24'h004000));
      add_line(write_line(REG_THETA_6, 24'h00C000));
      add_line(known_line(Q_TOP, 1'b0, 24'sd0, 24'sd8388607, 1'b0));
      add_line(known_line(Q_BOTTOM, 1'b0, 24'sd0, -24'sd8388608, 1'b0));
      add_line(known_line(Q_TOP, 1'b0, 24'sd0, 24'sd8388607, 1'b0));
      add_line(known_line(Q_BOTTOM, 1'b0, 24'sd0, -24'sd8388608, 1'b0));
      add_line(word_line(Q_TOP, 1'b0));
      add_line(word_line(24'h000001, 1'b0));
      add_line(word_line(Q_BOTTOM, 1'b0));
      // A new series in the middle of the stream starts the warm-up over.
      add_line(known_line(24'h123456, 1'b1, 24'sd0, 24'sd1193046, 1'b0));
      // Lowering the order to one ends the warm-up at once.
      add_line(write_line(CSR_ORDER, 24'd1));
      add_line(write_line(CSR_THETA_1, 24'h004000));
      add_line(word_line(24'h000200, 1'b0));
      add_line(word_line(24'hFFFF00, 1'b0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      settings_used = 1;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            if (i == 0 || plan[i-1].kind != ROW_WRITE) begin
               wait_until_idle();
               settings_used++;
            end
            write_reg(plan[i].reg_index, plan[i].reg_value);
         end else begin
            csr_we <= 1'b0;
            send_row(plan[i]);
         end
      end

      // Random phases: each one draws a fresh setting and takes the next of the
      // four idling patterns in turn, so gaps and stalls land on every stage of the
      // block's work. The first phases pin the order to its extremes.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_until_idle();
         case (ph % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 82;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 82;
            end
            default: begin
               sender_idle_pct = 38;
               receiver_stall_pct = 38;
            end
         endcase
         write_reg(CSR_MEAN_LEVEL, ($urandom_range(3) == 0) ? random_sample() :
                                   CSR_DATA_W'($urandom_range(4096) - 2048));
         case (ph)
            0: write_reg(CSR_ORDER, 24'd6);
            1: write_reg(CSR_ORDER, 24'd0);
            2: write_reg(CSR_ORDER, 24'd7);
            default: write_reg(CSR_ORDER, CSR_DATA_W'($urandom_range(7)));
         endcase
         for (int k = 0; k < MAX_ORDER; k++) begin
            write_reg(CSR_ADDR_W'(CSR_THETA_1 + k), CSR_DATA_W'(random_theta()));
         end
         settings_used++;
         csr_we <= 1'b0;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            send_row(word_line(random_sample(),
                               (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3)));
         end
      end

      wait_until_idle();
      repeat (40) @(posedge clock);

      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         errors++;
      end
      $display("Covered %0d sample words under %0d register settings.",
               words_sent, settings_used);
      $display("Checked %0d result words, %0d of them scored; %0d mismatches.",
               results_seen, scored_seen, errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
